FILE: hdl/sftx_pkg.sv
// Shared types, constants and lookup functions for the six-frame codon translator.
package sftx_pkg;

    // Standard genetic code, indexed by a codon in AGCT coding (A=0, G=1, C=2, T=3).
    // The first letter of the string is the entry for codon 0.
    localparam logic [8*64-1:0] AMINO_TABLE =
        "KKNNRRSSTTTTIMIIEEDDGGGGAAAAVVVVQQHHRRRRPPPPLLLL**YY*WCCSSSSLLFF";

    localparam logic [7:0] AMBIG_CHAR     = 8'h58;
    localparam logic [1:0] AMBIG_HOLD     = 2'd3;
    localparam logic [1:0] LAST_PHASE     = 2'd2;
    localparam logic [1:0] SEEN_TO_EMIT   = 2'd2;

    // One result of the translator.
    typedef struct packed {
        logic [1:0] frame;
        logic [7:0] fwd_amino;
        logic [7:0] rev_amino;
    } sftx_result_t;

    // Decoded base: a valid flag and a 2-bit AGCT code.
    typedef struct packed {
        logic       valid;
        logic [1:0] code;
    } sftx_base_t;

    // Maps an ASCII byte to its base code; anything but A, G, C, T is ambiguous.
    function automatic sftx_base_t decode_base(input logic [7:0] c);
        sftx_base_t b;
        b.valid = 1'b1;
        b.code  = 2'd0;
        case (c)
            "A", "a": b.code = 2'd0;
            "G", "g": b.code = 2'd1;
            "C", "c": b.code = 2'd2;
            "T", "t": b.code = 2'd3;
            default:  b.valid = 1'b0;
        endcase
        return b;
    endfunction

    // Looks up the amino acid letter of a codon.
    function automatic logic [7:0] amino_lookup(input logic [5:0] codon);
        return AMINO_TABLE[{~codon, 3'b000} +: 8];
    endfunction

endpackage

FILE: hdl/sftx_codon_state.sv
// Codon windows, frame phase and ambiguity tracking, with the amino acid lookup.
module sftx_codon_state
    import sftx_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         consume,
    input  logic [7:0]   base_char,
    input  logic         seq_start,
    output logic         emit,
    output sftx_result_t result
);

    logic [5:0] fwd_window_reg, fwd_window_next;
    logic [5:0] rev_window_reg, rev_window_next;
    logic [1:0] ambig_count_reg, ambig_count_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] seen_reg, seen_next;

    logic [5:0] fwd_cur, rev_cur;
    logic [1:0] ambig_cur, phase_cur, seen_cur;
    sftx_base_t base;

    // A start flag makes the item see the reset state.
    always_comb begin
        if (seq_start) begin
            fwd_cur   = '0;
            rev_cur   = '0;
            ambig_cur = '0;
            phase_cur = '0;
            seen_cur  = '0;
        end else begin
            fwd_cur   = fwd_window_reg;
            rev_cur   = rev_window_reg;
            ambig_cur = ambig_count_reg;
            phase_cur = phase_reg;
            seen_cur  = seen_reg;
        end
    end

    // Shift the new base into both windows and update the counters.
    always_comb begin
        base            = decode_base(base_char);
        fwd_window_next = {fwd_cur[3:0], 2'b00};
        rev_window_next = {2'b00, rev_cur[5:2]};
        ambig_count_next = (ambig_cur != 2'd0) ? ambig_cur - 2'd1 : 2'd0;
        if (base.valid) begin
            fwd_window_next[1:0] = base.code;
            rev_window_next[5:4] = ~base.code;
        end else begin
            ambig_count_next = AMBIG_HOLD;
        end
        seen_next  = (seen_cur < SEEN_TO_EMIT) ? seen_cur + 2'd1 : seen_cur;
        phase_next = (phase_cur >= LAST_PHASE) ? 2'd0 : phase_cur + 2'd1;
    end

    // Result for the current item; valid only when emit is high.
    always_comb begin
        emit         = (seen_cur == SEEN_TO_EMIT);
        result.frame = phase_cur;
        if (ambig_count_next == 2'd0) begin
            result.fwd_amino = amino_lookup(fwd_window_next);
            result.rev_amino = amino_lookup(rev_window_next);
        end else begin
            result.fwd_amino = AMBIG_CHAR;
            result.rev_amino = AMBIG_CHAR;
        end
    end

    // Running state advances once per consumed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_window_reg  <= '0;
            rev_window_reg  <= '0;
            ambig_count_reg <= '0;
            phase_reg       <= '0;
            seen_reg        <= '0;
        end else if (consume) begin
            fwd_window_reg  <= fwd_window_next;
            rev_window_reg  <= rev_window_next;
            ambig_count_reg <= ambig_count_next;
            phase_reg       <= phase_next;
            seen_reg        <= seen_next;
        end
    end

`ifndef ASSERT_OFF
    // The phase cycles through 0, 1 and 2 only.
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3) else $error("phase left its range");

    // The base count saturates at two.
    a_seen_range: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg != 2'd3) else $error("base count overran");

    // An ambiguous base always forces both letters to X on the same item.
    a_ambig_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !base.valid) |->
            (result.fwd_amino == AMBIG_CHAR && result.rev_amino == AMBIG_CHAR))
        else $error("ambiguous base not marked");
`endif

endmodule

FILE: hdl/six_frame_codon_translator.sv
// Top level of the six-frame codon translator: input register, translation and result register.
//
// Usage:
//   The slave channel takes one ASCII nucleotide per transaction in s_tdata; s_tuser
//   set marks the first base of a new sequence and clears the running state.
//   A, G, C and T in either case are valid; any other byte is ambiguous.
//   From the third base of a sequence on, each base gives one master transaction:
//   m_tuser holds the reading frame (0 to 2), m_tdata the forward amino acid in the
//   low byte and the reverse-complement amino acid (for frame + 3) in the high byte.
//   Either letter reads 'X' while an ambiguous base is within the codon window.
//   The first two bases of a sequence give no transaction.
// Timing:
//   A base passes an input register and then the result register before its result
//   is presented. One base per cycle is sustained while m_tready stays high; the rate is set
//   by the combinational window update and 64-entry table lookup between the registers.
// Reset and stalls:
//   After reset both registers are empty and the state equals that after a start flag.
//   When the receiver holds m_tready low, the result register keeps its transaction,
//   one more base waits in the input register, and then s_tready drops. Bases that
//   give no result still drain while the output is stalled.
module six_frame_codon_translator
    import sftx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] base_char
    input  logic [0:0]  s_tuser,   // [0] seq_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] fwd_amino, [15:8] rev_amino
    output logic [1:0]  m_tuser    // [1:0] frame
);

    logic         in_valid_reg;
    logic [7:0]   in_char_reg;
    logic         in_start_reg;
    logic         out_valid_reg;
    sftx_result_t out_result_reg;

    logic         emit;
    logic         consume;
    logic         out_free;
    sftx_result_t result;

    sftx_codon_state u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .consume   (consume),
        .base_char (in_char_reg),
        .seq_start (in_start_reg),
        .emit      (emit),
        .result    (result)
    );

    // An item leaves the input register when it gives no result or the output has room.
    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && (!emit || out_free);
    assign s_tready = !in_valid_reg || consume;

    // Input register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
    end

    // Result register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= consume && emit;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (consume && emit) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_result_reg.rev_amino, out_result_reg.fwd_amino};
    assign m_tuser  = out_result_reg.frame;

`ifndef ASSERT_OFF
    // The input side stalls only while a base is held in the input register.
    a_stall_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg) else $error("stall without a pending item");
`endif

endmodule

FILE: test/tb_six_frame_codon_translator.sv
// Testbench for the six-frame codon translator: stream stimulus, codon prediction and result checks.
`timescale 1ns / 1ps

module tb_six_frame_codon_translator
    import sftx_pkg::*;
();

    // Nucleotide codes as the translator packs them into a codon window.
    typedef enum logic [1:0] {NT_A = 2'd0, NT_G = 2'd1, NT_C = 2'd2, NT_T = 2'd3} nt_code_e;

    // One base waiting to be driven, with the idle cycles that precede it.
    typedef struct {
        logic [7:0] base;
        logic       start;
        int         gap;
    } base_txn_t;

    localparam int    IDLE_LIMIT  = 2000;
    localparam int    DRAIN_WAIT  = 8;
    localparam int    MAX_REPORTS = 10;
    // Amino acid letters of the standard genetic code, indexed by codon value.
    localparam string GENETIC_CODE =
        "KKNNRRSSTTTTIMIIEEDDGGGGAAAAVVVVQQHHRRRRPPPPLLLL**YY*WCCSSSSLLFF";
    localparam string UPPER_BASES = "AGCT";
    localparam string LOWER_BASES = "agct";

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] base_char
    logic [0:0]  s_tuser = 1'b0;    // [0] seq_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [7:0] fwd_amino, [15:8] rev_amino
    logic [1:0]  m_tuser;           // [1:0] frame

    // Stimulus and prediction state.
    base_txn_t    pending_bases[$];
    sftx_result_t expected_aminos[$];
    logic [5:0]   fwd_win = '0;
    logic [5:0]   rev_win = '0;
    logic [1:0]   ambig_left = '0;
    logic [1:0]   frame_pos = '0;
    logic [1:0]   bases_taken = '0;
    bit           tx_calm = 1'b0;
    bit           rx_calm = 1'b0;
    int           tx_gap_left = 0;
    int           rx_hold_left = 0;
    int           rx_mode_count = 0;
    int           idle_count = 0;

    // Run statistics.
    int unsigned  bases_total = 0;
    int unsigned  bases_accepted = 0;
    int unsigned  sequences = 0;
    int unsigned  ambig_bases = 0;
    int unsigned  results_checked = 0;
    int unsigned  masked_results = 0;
    int unsigned  mismatches = 0;

    six_frame_codon_translator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 50 MHz clock.
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Decodes an ASCII byte; returns 0 for an ambiguous base.
    function automatic bit decode_nt(input logic [7:0] c, output logic [1:0] code);
        code = NT_A;
        case (c)
            "A", "a": code = NT_A;
            "G", "g": code = NT_G;
            "C", "c": code = NT_C;
            "T", "t": code = NT_T;
            default:  return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Queues one base for the driver.
    function automatic void add_base(input logic [7:0] c, input bit start);
        base_txn_t t;
        logic [1:0] code;
        t.base  = c;
        t.start = start;
        t.gap   = tx_calm ? 0 : idle_cycles();
        pending_bases.push_back(t);
        bases_total++;
        if (start) sequences++;
        if (!decode_nt(c, code)) ambig_bases++;
    endfunction

    // Queues a string of bases, the first one optionally flagged as a sequence start.
    function automatic void add_seq(input string s, input bit start);
        for (int i = 0; i < s.len(); i++) add_base(s[i], start && (i == 0));
    endfunction

    // Any byte other than A, G, C or T in either case.
    function automatic logic [7:0] random_ambig();
        logic [7:0] c;
        logic [1:0] code;
        do c = 8'($urandom_range(0, 255)); while (decode_nt(c, code));
        return c;
    endfunction

    // Advances the codon windows by one base and records the translation it yields.
    function automatic void translate_base(input logic [7:0] c, input bit start);
        logic [1:0]   code;
        sftx_result_t r;
        if (start) begin
            fwd_win     = '0;
            rev_win     = '0;
            ambig_left  = '0;
            frame_pos   = '0;
            bases_taken = '0;
        end
        r.frame = frame_pos;
        fwd_win = fwd_win << 2;
        rev_win = rev_win >> 2;
        if (ambig_left != 0) ambig_left--;
        if (!decode_nt(c, code)) begin
            ambig_left = AMBIG_HOLD;
        end else begin
            // The reverse window takes the complement at its top end.
            fwd_win = fwd_win | {4'b0000, code};
            rev_win = rev_win | {~code, 4'b0000};
        end
        frame_pos = (frame_pos == LAST_PHASE) ? 2'd0 : frame_pos + 2'd1;
        // The first two bases of a sequence only fill the window.
        if (bases_taken < SEEN_TO_EMIT) begin
            bases_taken++;
            return;
        end
        if (ambig_left != 0) begin
            r.fwd_amino = AMBIG_CHAR;
            r.rev_amino = AMBIG_CHAR;
        end else begin
            r.fwd_amino = GENETIC_CODE[fwd_win];
            r.rev_amino = GENETIC_CODE[rev_win];
        end
        expected_aminos.push_back(r);
    endfunction

    function automatic void report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%0t: MISMATCH %s", $realtime, msg);
    endfunction

    // Compares one result transaction with the oldest predicted translation.
    function automatic void check_result();
        sftx_result_t want;
        if (expected_aminos.size() == 0) begin
            report_mismatch($sformatf("unexpected result frame=%0d fwd=%h rev=%h",
                                      m_tuser, m_tdata[7:0], m_tdata[15:8]));
            return;
        end
        want = expected_aminos.pop_front();
        results_checked++;
        if (want.fwd_amino == AMBIG_CHAR) masked_results++;
        if (m_tuser != want.frame || m_tdata[7:0] != want.fwd_amino ||
            m_tdata[15:8] != want.rev_amino) begin
            report_mismatch($sformatf(
                "result %0d: expected frame=%0d fwd=%h rev=%h, got frame=%0d fwd=%h rev=%h",
                results_checked, want.frame, want.fwd_amino, want.rev_amino,
                m_tuser, m_tdata[7:0], m_tdata[15:8]));
        end
    endfunction

    // Driver: presents queued bases, idling before each one as scheduled.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_gap_left != 0) begin
                tx_gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_bases.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_bases[0].base;
                s_tuser  <= pending_bases[0].start;
                void'(pending_bases.pop_front());
                tx_gap_left = (pending_bases.size() != 0) ? pending_bases[0].gap : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, switched off for whole stretches now and then.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b1;
        end else begin
            rx_mode_count++;
            if (rx_mode_count == 400) begin
                rx_mode_count = 0;
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!rx_calm) rx_hold_left = idle_cycles();
            end
        end
    end

    // Monitor: predicts on each accepted base, then checks each accepted result.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                translate_base(s_tdata, s_tuser[0]);
                bases_accepted++;
            end
            if (m_tvalid && m_tready) check_result();
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_count = 0;
            else idle_count++;
            if (idle_count >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, expected_aminos.size());
                $display("tb_six_frame_codon_translator: errors");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int len;
        int kind;
        logic [7:0] c;

        // Directed: no start flag right after reset, then a second base of a frame.
        add_seq("ATGC", 1'b0);
        // Lower-case bases.
        add_seq("atggct", 1'b1);
        // Sequences shorter than three bases give nothing.
        add_seq("GC", 1'b1);
        add_seq("T", 1'b1);
        // An ambiguous base masks three results.
        add_seq("TANGAT", 1'b1);
        // Byte extremes, including bytes above 127.
        add_base(8'h00, 1'b1);
        add_base("C", 1'b0);
        add_base(8'hFF, 1'b0);
        add_base(8'h80, 1'b0);
        add_seq("AAA", 1'b0);

        // Random sequences: mostly valid bases of either case, some ambiguous bytes.
        while (bases_total < 1450) begin
            tx_calm = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 19);
            if (kind == 0) len = $urandom_range(1, 2);
            else if (kind < 17) len = $urandom_range(3, 30);
            else len = $urandom_range(31, 120);
            for (int i = 0; i < len; i++) begin
                kind = $urandom_range(0, 99);
                if (kind < 44) c = UPPER_BASES[$urandom_range(0, 3)];
                else if (kind < 86) c = LOWER_BASES[$urandom_range(0, 3)];
                else c = random_ambig();
                add_base(c, (i == 0) && ($urandom_range(0, 19) != 0));
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every base, then every translation, then a quiet tail.
        while (bases_accepted < bases_total) @(posedge aclk);
        while (expected_aminos.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Sent %0d bases in about %0d sequences, %0d of them ambiguous.",
                 bases_total, sequences, ambig_bases);
        $display("Checked %0d translations, %0d masked by ambiguity; %0d mismatches.",
                 results_checked, masked_results, mismatches);
        if (mismatches == 0 && expected_aminos.size() == 0) begin
            $display("tb_six_frame_codon_translator: clean");
        end else begin
            $display("tb_six_frame_codon_translator: errors");
        end
        $finish;
    end

endmodule
